FILE: src/chained_hash_table_top_assert.svh
// Assertion macros for the chained hash table.
// Included by the top level; expects clk and rst_n in scope.
`ifndef CHAINED_HASH_TABLE_TOP_ASSERT_SVH
`define CHAINED_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define CHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cht_pkg.sv
// Shared types and codes for the chained hash table.
// No dependencies.
package cht_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_DELETED  = 3'd2;
    localparam logic [2:0] ST_ABSENT   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam int KEY_PORT_BITS   = 32;
    localparam int VALUE_PORT_BITS = 32;
    localparam int CFG_BITS        = 9;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 9'd256;

    typedef struct packed {
        logic        op;
        logic [31:0] key;
        logic [31:0] value;
    } cht_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] bucket_index;
        logic [8:0] entry_count;
    } cht_rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cht_div_stat_t;

endpackage

FILE: src/cht_stream_if.sv
// Valid/ready stream interface carrying one payload type.
// No dependencies; the payload type is a parameter.
interface cht_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/cht_mod_unit.sv
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// Depends on cht_pkg (status struct).
module cht_mod_unit import cht_pkg::*; #(
    parameter int NUM_BITS = 32,
    parameter int REM_BITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [REM_BITS-1:0] modulus,
    output cht_div_stat_t       stat,
    output logic [REM_BITS-1:0] remainder
);
    localparam int CNT_W = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NUM_BITS-1:0] sh_reg, sh_next;
    logic [REM_BITS-1:0] rem_reg, rem_next;
    logic [REM_BITS-1:0] mod_reg, mod_next;
    logic [REM_BITS-1:0] trial;

    // remainder stays below the modulus, so the top bit is free for the shift
    assign trial = {rem_reg[REM_BITS-2:0], sh_reg[NUM_BITS-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        mod_next  = mod_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_BITS - 1);
            sh_next   = dividend;
            rem_next  = '0;
            mod_next  = modulus;
        end
        else if (busy_reg)
        begin
            sh_next  = sh_reg << 1;
            rem_next = (trial >= mod_reg) ? (trial - mod_reg) : trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        mod_reg <= mod_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;
endmodule

FILE: src/chained_hash_table_top.sv
// Chained hash table top level: sequencer, node pool memories, free stack.
// Depends on cht_pkg, cht_stream_if, cht_ram, cht_mod_unit and the assert header.
//
// Usage:
//   req (sink) carries op/key/value transactions; rsp (source) returns one
//   status/bucket_index/entry_count transaction per request. cfg_we/cfg_wdata
//   write bucket_count (reset 256); write it only while the block is idle.
//   After reset a clearing pass empties every bucket and fills the free
//   stack; req.ready stays low meanwhile. One request at a time: req.ready
//   is high only while idle. A request runs the bit-serial modulo of the
//   key, reads the bucket head, then takes a registered node-memory read
//   for each chain node it visits. An insert of a new key adds a step to
//   allocate and one more to link it at a non-empty chain's tail; a delete
//   adds a step to clear the unlinked node's next pointer.
//   The result holds in the output until rsp.ready; a stalled receiver keeps
//   the block from taking the next request.
module chained_hash_table_top import cht_pkg::*; #(
    parameter int BUCKETS    = 256,
    parameter int POOL_NODES = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    cht_stream_if.sink          req,
    cht_stream_if.source        rsp
);
`include "chained_hash_table_top_assert.svh"

    localparam int KW    = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
    localparam int VW    = (VALUE_BITS < VALUE_PORT_BITS) ? VALUE_BITS : VALUE_PORT_BITS;
    localparam int BW    = $clog2(BUCKETS);
    localparam int IW    = $clog2(POOL_NODES);
    localparam int NW    = $clog2(POOL_NODES + 1);
    localparam int CW    = (BW + 1 > CFG_BITS) ? BW + 1 : CFG_BITS;
    localparam int DW    = CW + 1;
    localparam int CLR_N = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
    localparam int CLRW  = $clog2(CLR_N);
    localparam logic [NW-1:0] NO_NODE = NW'(POOL_NODES);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_NCHK  = 4'd5;
    localparam logic [3:0] S_ACT   = 4'd6;
    localparam logic [3:0] S_ALLOC = 4'd7;
    localparam logic [3:0] S_LINK  = 4'd8;
    localparam logic [3:0] S_DUNL  = 4'd9;
    localparam logic [3:0] S_RESP  = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [CFG_BITS-1:0] cfg_reg;
    logic [CLRW-1:0]     clr_reg, clr_next;
    logic [NW-1:0]       ftop_reg, ftop_next;
    logic [NW-1:0]       cnt_reg, cnt_next;
    logic [NW-1:0]       steps_reg, steps_next;
    logic [NW-1:0]       cur_reg, cur_next;
    logic [NW-1:0]       prev_reg, prev_next;
    logic [NW-1:0]       nxt_reg, nxt_next;
    logic [NW-1:0]       node_reg, node_next;
    logic                found_reg, found_next;
    logic [2:0]          status_reg, status_next;
    logic                op_reg, op_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [VW-1:0]       val_reg, val_next;
    logic [BW-1:0]       bkt_reg, bkt_next;

    logic [CW-1:0]       cfg_ext;
    logic [DW-1:0]       modulus;
    logic [DW-1:0]       rem;
    cht_div_stat_t       div_stat;
    logic                accept;

    // memory ports
    logic                head_we;
    logic [BW-1:0]       head_waddr, head_raddr;
    logic [NW-1:0]       head_wdata, head_rdata;
    logic                nkey_we;
    logic [KW-1:0]       nkey_rdata;
    logic                nnext_we;
    logic [IW-1:0]       nnext_waddr;
    logic [NW-1:0]       nnext_wdata, nnext_rdata;
    logic                free_we;
    logic [IW-1:0]       free_waddr, free_raddr;
    logic [IW-1:0]       free_wdata, free_rdata;
    logic [IW-1:0]       alloc_idx;
    logic [31:0]         cnt_wide, bkt_wide;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    // 0 acts as 1, anything above BUCKETS acts as BUCKETS
    assign cfg_ext = CW'(cfg_reg);
    always_comb
    begin
        priority if (cfg_ext == '0)
            modulus = DW'(1);
        else if (cfg_ext > CW'(BUCKETS))
            modulus = DW'(BUCKETS);
        else
            modulus = DW'(cfg_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    cht_mod_unit #(
        .NUM_BITS (KW),
        .REM_BITS (DW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (req.payload.key[KW-1:0]),
        .modulus   (modulus),
        .stat      (div_stat),
        .remainder (rem)
    );

    assign head_raddr = (state_reg == S_MOD) ? rem[BW-1:0] : bkt_reg;
    assign free_raddr = IW'(ftop_reg - 1'b1);
    assign alloc_idx  = free_rdata;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        ftop_next   = ftop_reg;
        cnt_next    = cnt_reg;
        steps_next  = steps_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        nxt_next    = nxt_reg;
        node_next   = node_reg;
        found_next  = found_reg;
        status_next = status_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        bkt_next    = bkt_reg;

        head_we     = 1'b0;
        head_waddr  = bkt_reg;
        head_wdata  = NO_NODE;
        nkey_we     = 1'b0;
        nnext_we    = 1'b0;
        nnext_waddr = cur_reg[IW-1:0];
        nnext_wdata = NO_NODE;
        free_we     = 1'b0;
        free_waddr  = ftop_reg[IW-1:0];
        free_wdata  = cur_reg[IW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                head_we    = ({1'b0, clr_reg} < (CLRW+1)'(BUCKETS));
                head_waddr = clr_reg[BW-1:0];
                free_we    = ({1'b0, clr_reg} < (CLRW+1)'(POOL_NODES));
                free_waddr = clr_reg[IW-1:0];
                free_wdata = IW'(POOL_NODES - 1) - clr_reg[IW-1:0];
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == CLRW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.payload.op;
                    key_next   = req.payload.key[KW-1:0];
                    val_next   = req.payload.value[VW-1:0];
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (div_stat.done)
                begin
                    bkt_next   = rem[BW-1:0];
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cur_next   = head_rdata;
                prev_next  = NO_NODE;
                steps_next = '0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (cur_reg >= NO_NODE || steps_reg == NW'(POOL_NODES))
                begin
                    found_next = 1'b0;
                    state_next = S_ACT;
                end
                else
                begin
                    state_next = S_NCHK;
                end
            end
            S_NCHK:
            begin
                if (nkey_rdata == key_reg)
                begin
                    found_next = 1'b1;
                    nxt_next   = nnext_rdata;
                    state_next = S_ACT;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = nnext_rdata;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WALK;
                end
            end
            S_ACT:
            begin
                if (op_reg == OP_INSERT)
                begin
                    priority if (found_reg)
                    begin
                        nkey_we     = 1'b1;
                        status_next = ST_UPDATED;
                        state_next  = S_RESP;
                    end
                    else if (ftop_reg == '0)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_ALLOC;
                    end
                end
                else if (!found_reg)
                begin
                    status_next = ST_ABSENT;
                    state_next  = S_RESP;
                end
                else
                begin
                    if (prev_reg == NO_NODE)
                    begin
                        head_we    = 1'b1;
                        head_wdata = nxt_reg;
                    end
                    else
                    begin
                        nnext_we    = 1'b1;
                        nnext_waddr = prev_reg[IW-1:0];
                        nnext_wdata = nxt_reg;
                    end
                    if (ftop_reg < NW'(POOL_NODES))
                    begin
                        free_we   = 1'b1;
                        ftop_next = ftop_reg + 1'b1;
                    end
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                    status_next = ST_DELETED;
                    state_next  = S_DUNL;
                end
            end
            S_ALLOC:
            begin
                nkey_we     = 1'b1;
                nnext_we    = 1'b1;
                nnext_waddr = alloc_idx;
                nnext_wdata = NO_NODE;
                node_next   = NW'(alloc_idx);
                ftop_next   = ftop_reg - 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                status_next = ST_INSERTED;
                if (prev_reg == NO_NODE)
                begin
                    head_we    = 1'b1;
                    head_wdata = NW'(alloc_idx);
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                nnext_we    = 1'b1;
                nnext_waddr = prev_reg[IW-1:0];
                nnext_wdata = node_reg;
                state_next  = S_RESP;
            end
            S_DUNL:
            begin
                nnext_we    = 1'b1;
                nnext_waddr = cur_reg[IW-1:0];
                nnext_wdata = NO_NODE;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ftop_reg  <= NW'(POOL_NODES);
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ftop_reg  <= ftop_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg  <= steps_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        node_reg   <= node_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        bkt_reg    <= bkt_next;
    end

    // node key and value share the write address: current node or new node
    logic [IW-1:0] nkv_waddr;
    assign nkv_waddr = (state_reg == S_ALLOC) ? alloc_idx : cur_reg[IW-1:0];

    cht_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    cht_ram #(.WIDTH(KW), .DEPTH(POOL_NODES)) u_nkey (
        .clk   (clk),
        .we    (nkey_we && state_reg == S_ALLOC),
        .waddr (nkv_waddr),
        .wdata (key_reg),
        .raddr (cur_reg[IW-1:0]),
        .rdata (nkey_rdata)
    );

    cht_ram #(.WIDTH(VW), .DEPTH(POOL_NODES)) u_nval (
        .clk   (clk),
        .we    (nkey_we),
        .waddr (nkv_waddr),
        .wdata (val_reg),
        .raddr (cur_reg[IW-1:0]),
        .rdata ()
    );

    cht_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_nnext (
        .clk   (clk),
        .we    (nnext_we),
        .waddr (nnext_waddr),
        .wdata (nnext_wdata),
        .raddr (cur_reg[IW-1:0]),
        .rdata (nnext_rdata)
    );

    cht_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_free (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    assign cnt_wide = 32'(cnt_reg);
    assign bkt_wide = 32'(bkt_reg);
    assign rsp.valid                = (state_reg == S_RESP);
    assign rsp.payload.status       = status_reg;
    assign rsp.payload.bucket_index = bkt_wide[7:0];
    assign rsp.payload.entry_count  = cnt_wide[8:0];

    `CHT_ASSERT_NOW(a_ready_excl, req.ready, !rsp.valid,
        "request taken while a response is pending")
    `CHT_ASSERT_NOW(a_pool_balance, state_reg != S_CLEAR,
        (32'(ftop_reg) + 32'(cnt_reg)) == POOL_NODES, "free count and entry count disagree")
    `CHT_ASSERT_NOW(a_div_only_mod, div_stat.busy, state_reg == S_MOD,
        "modulo unit busy outside the hashing step")
    `CHT_ASSERT_NEXT(a_mod_done, div_stat.done && state_reg == S_MOD,
        32'(bkt_reg) < 32'(modulus), "bucket index not below bucket count")
endmodule

FILE: tb/cht_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the chained hash table: mirrors the table in software and
// checks each response transaction. Depends on cht_pkg.
class cht_scoreboard;
    localparam int NBKT = 256;
    localparam int NPOOL = 256;
    localparam int NIL = NPOOL;

    int unsigned buckets_in_use;
    int unsigned head[NBKT];
    logic [31:0] nkey[NPOOL];
    logic [31:0] nval[NPOOL];
    int unsigned nnext[NPOOL];
    int unsigned free_list[NPOOL];
    int unsigned free_cnt;
    int unsigned stored;
    cht_pkg::cht_rsp_t pending[$];
    int errors;

    function new();
        buckets_in_use = 256;
        for (int i = 0; i < NBKT; i++)
        begin
            head[i] = NIL;
        end
        for (int i = 0; i < NPOOL; i++)
        begin
            nnext[i] = NIL;
            nkey[i] = '0;
            nval[i] = '0;
            free_list[i] = NPOOL - 1 - i;
        end
        free_cnt = NPOOL;
        stored = 0;
        errors = 0;
    endfunction

    function void set_buckets(logic [8:0] v);
        buckets_in_use = (v == 0) ? 1 : ((v > NBKT) ? NBKT : v);
    endfunction

    function int unsigned count();
        return stored;
    endfunction

    function void note_request(cht_pkg::cht_req_t r);
        int unsigned b;
        int unsigned prev;
        int unsigned cur;
        int unsigned n;
        int unsigned steps;
        cht_pkg::cht_rsp_t e;
        b = r.key % buckets_in_use;
        prev = NIL;
        cur = head[b];
        steps = 0;
        while (cur != NIL && steps < NPOOL && nkey[cur] != r.key)
        begin
            prev = cur;
            cur = nnext[cur];
            steps++;
        end
        if (cur == NIL || steps >= NPOOL || nkey[cur] != r.key)
            cur = NIL;
        if (r.op == cht_pkg::OP_INSERT)
        begin
            if (cur != NIL)
            begin
                nval[cur] = r.value;
                e.status = cht_pkg::ST_UPDATED;
            end
            else if (free_cnt == 0)
                e.status = cht_pkg::ST_FULL;
            else
            begin
                free_cnt--;
                n = free_list[free_cnt];
                nkey[n] = r.key;
                nval[n] = r.value;
                nnext[n] = NIL;
                if (prev == NIL)
                    head[b] = n;
                else
                    nnext[prev] = n;
                stored++;
                e.status = cht_pkg::ST_INSERTED;
            end
        end
        else if (cur == NIL)
            e.status = cht_pkg::ST_ABSENT;
        else
        begin
            if (prev == NIL)
                head[b] = nnext[cur];
            else
                nnext[prev] = nnext[cur];
            nnext[cur] = NIL;
            free_list[free_cnt] = cur;
            free_cnt++;
            stored--;
            e.status = cht_pkg::ST_DELETED;
        end
        e.bucket_index = b[7:0];
        e.entry_count = stored[8:0];
        pending.push_back(e);
    endfunction

    function void check_response(cht_pkg::cht_rsp_t got);
        cht_pkg::cht_rsp_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected response transaction");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.status !== e.status)
        begin
            $error("status expected %0d actual %0d", e.status, got.status);
            errors++;
        end
        if (got.bucket_index !== e.bucket_index)
        begin
            $error("bucket_index expected %0d actual %0d", e.bucket_index, got.bucket_index);
            errors++;
        end
        if (got.entry_count !== e.entry_count)
        begin
            $error("entry_count expected %0d actual %0d", e.entry_count, got.entry_count);
            errors++;
        end
    endfunction
endclass

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the chained hash table testbench: clock, reset, drivers, monitor.
// Depends on cht_pkg, cht_stream_if, cht_scoreboard.sv and the DUT.
module testbench;
    import cht_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_BITS-1:0] cfg_wdata = '0;
    bit quiet = 1'b0;       // no idling in the last part
    bit hold_rsp = 1'b0;    // long receiver hold-off
    int unsigned cycles = 0;
    logic [31:0] keys_used[$];

    cht_stream_if #(.T(cht_req_t)) req ();
    cht_stream_if #(.T(cht_rsp_t)) rsp ();

    cht_scoreboard table_mirror = new();

    chained_hash_table_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req(req), .rsp(rsp)
    );

    always #6 clk = ~clk;

    initial
    begin
        req.valid = 1'b0;
        req.payload = '0;
        rsp.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Accepted transactions
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            table_mirror.note_request(req.payload);
        if (rst_n && rsp.valid && rsp.ready)
            table_mirror.check_response(rsp.payload);
    end

    // Receiver: random stall bursts, plus the hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
                rsp.ready <= 1'b0;
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n - 1) @(negedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // valid stays high after acceptance until the next call drives it; the
    // block is busy by then, so nothing is taken twice
    task automatic send(input logic op, input logic [31:0] key, input logic [31:0] value);
        cht_req_t r;
        int n;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 13);
            req.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        r.op = op;
        r.key = key;
        r.value = value;
        req.valid <= 1'b1;
        req.payload <= r;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (table_mirror.pending.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic write_buckets(input logic [8:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        table_mirror.set_buckets(v);
    endtask

    function automatic logic [31:0] pick_key(input int unsigned span);
        if (keys_used.size() != 0 && $urandom_range(0, 2) != 0)
            return keys_used[$urandom_range(0, keys_used.size() - 1)];
        return (span == 0) ? $urandom() : $urandom_range(0, span);
    endfunction

    task automatic random_phase(input int items, input int unsigned span, input int del_pct);
        logic [31:0] k;
        logic op;
        for (int i = 0; i < items; i++)
        begin
            k = pick_key(span);
            op = ($urandom_range(0, 99) < del_pct) ? OP_DELETE : OP_INSERT;
            if (op == OP_INSERT && keys_used.size() < 400)
                keys_used.push_back(k);
            send(op, k, $urandom());
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, update, chain middle/head delete, absent delete
        send(OP_INSERT, 32'h0, 32'h0);
        send(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_INSERT, 32'h0, 32'hA5A5_5A5A);
        send(OP_INSERT, 32'd256, 32'h1);
        send(OP_INSERT, 32'd512, 32'h2);
        send(OP_DELETE, 32'd256, 32'h0);
        send(OP_DELETE, 32'd256, 32'h0);
        send(OP_DELETE, 32'd0, 32'h0);
        send(OP_DELETE, 32'd512, 32'h0);
        send(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_DELETE, 32'h8000_0000, 32'h0);

        // Zero acts as one bucket: one long chain
        write_buckets(9'd0);
        for (int i = 0; i < 8; i++)
            send(OP_INSERT, i * 7, i);
        send(OP_DELETE, 32'd21, 32'h0);
        send(OP_INSERT, 32'd21, 32'h5);
        // Above the table size acts as 256; entries above are not rehashed
        write_buckets(9'd511);
        send(OP_DELETE, 32'd14, 32'h0);
        send(OP_INSERT, 32'd14, 32'h9);

        // Fill the pool to full with distinct keys
        write_buckets(9'd37);
        for (int i = 0; i < 300; i++)
            send(OP_INSERT, 32'h0010_0000 + 32'(i), 32'(i));
        send(OP_INSERT, 32'hDEAD_BEEF, 32'h1);

        // Receiver hold-off while the sender keeps offering
        fork
            begin
                hold_rsp = 1'b1;
                repeat (400) @(posedge clk);
                hold_rsp = 1'b0;
            end
            random_phase(10, 0, 100);
        join
        drain();     // sender pause until everything has come back

        write_buckets(9'd1);
        random_phase(200, 2000, 55);
        write_buckets(9'd256);
        random_phase(500, 0, 45);
        write_buckets(9'd2);
        random_phase(200, 500, 50);
        write_buckets(9'd255);
        quiet = 1'b1;
        random_phase(200, 0, 40);

        drain();
        if (table_mirror.errors == 0 && table_mirror.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
